### hdl/tun_pkg.sv
// Shared constants and types for the triangle unit normal pipeline.
package tun_pkg;

  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int NORM_TOP             = 30;
  localparam int OUT_W                = 16;
  localparam int SQ_W                 = 2 * NORM_TOP + 2;
  localparam int ROOT_W               = NORM_TOP + 1;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } side_t;

endpackage

### hdl/tun_cross.sv
// Three-stage cross product: coordinate differences, products, negated sums.
module tun_cross import tun_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int MAG_W = 2 * COORD_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] crd [3][3],
  output logic                         out_valid,
  output logic [MAG_W-1:0]             mag [3],
  output logic [2:0]                   neg
);

  localparam int D_W = COORD_BITS + 1;
  localparam int P_W = 2 * COORD_BITS + 1;
  localparam int S_W = 2 * COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] u1 [3][3];
  logic signed [D_W-1:0]        d1 [3][3];
  logic signed [P_W-1:0]        p2 [3][3];
  logic signed [S_W-1:0]        nsum [3];
  logic                         v1, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // component k multiplies axis k+1 by differences along axis k+2
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          u1[k][i] <= crd[i][(k+1)%3];
          d1[k][i] <= D_W'(crd[(i+1)%3][(k+2)%3]) - D_W'(crd[(i+2)%3][(k+2)%3]);
          p2[k][i] <= P_W'(u1[k][i]) * P_W'(d1[k][i]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nsum[k] = -(S_W'(p2[k][0]) + S_W'(p2[k][1]) + S_W'(p2[k][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg[k] <= nsum[k][S_W-1];
        mag[k] <= MAG_W'(nsum[k][S_W-1] ? -nsum[k] : nsum[k]);
      end
    end
  end

endmodule

### hdl/tun_norm.sv
// Normalisation: maximum, bit length, common shift, squares and their sum.
module tun_norm import tun_pkg::*; #(
  parameter int MAG_W = 2 * COORD_BITS_DEF + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [MAG_W-1:0]    mag [3],
  input  logic [2:0]          neg,
  output logic                out_valid,
  output logic [SQ_W-1:0]     sq,
  output logic [NORM_TOP-1:0] smag [3],
  output side_t               side
);

  localparam int NCH = (MAG_W + 7) / 8;
  localparam int PW  = NCH * 8;
  localparam int BLW = $clog2(MAG_W + 1);
  localparam int EW  = MAG_W + NORM_TOP;

  logic                    va, vb, vc, vd, ve;
  logic [MAG_W-1:0]        a_mag [3];
  logic [MAG_W-1:0]        a_m;
  logic [2:0]              a_neg;
  logic [MAG_W-1:0]        b_mag [3];
  logic [NCH-1:0]          b_nz;
  logic [3:0]              b_lb [NCH];
  logic [2:0]              b_neg;
  logic [MAG_W-1:0]        c_mag [3];
  logic [BLW-1:0]          c_bl;
  side_t                   c_side;
  logic [NORM_TOP-1:0]     d_smag [3];
  side_t                   d_side;
  logic [2*NORM_TOP-1:0]   e_sq [3];
  logic [NORM_TOP-1:0]     e_smag [3];
  side_t                   e_side;

  logic [MAG_W-1:0]        m_max;
  logic [PW-1:0]           m_pad;
  logic [NCH-1:0]          nz_c;
  logic [3:0]              lb_c [NCH];
  logic [BLW-1:0]          bl_c;
  logic [EW-1:0]           ext [3];
  logic [EW-1:0]           shf [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      ve        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      ve        <= vd;
      out_valid <= ve;
    end
  end

  always_comb begin
    m_max = mag[0];
    if (mag[1] > m_max) m_max = mag[1];
    if (mag[2] > m_max) m_max = mag[2];
  end

  // per-byte bit length of the maximum
  always_comb begin
    m_pad = PW'(a_m);
    for (int c = 0; c < NCH; c++) begin
      nz_c[c] = |m_pad[c*8 +: 8];
      lb_c[c] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        if (m_pad[c*8+b]) lb_c[c] = 4'(b + 1);
      end
    end
  end

  always_comb begin
    bl_c = '0;
    for (int c = 0; c < NCH; c++) begin
      if (b_nz[c]) bl_c = BLW'(c * 8 + int'(b_lb[c]));
    end
  end

  // bring the top set bit of the maximum to the top of the working width
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ext[j] = EW'(c_mag[j]);
      if (int'(c_bl) > NORM_TOP) shf[j] = ext[j] >> (int'(c_bl) - NORM_TOP);
      else                       shf[j] = ext[j] << (NORM_TOP - int'(c_bl));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag <= mag;
      a_m   <= m_max;
      a_neg <= neg;

      b_mag <= a_mag;
      b_nz  <= nz_c;
      b_lb  <= lb_c;
      b_neg <= a_neg;

      c_mag        <= b_mag;
      c_bl         <= bl_c;
      c_side.degen <= ~|b_nz;
      c_side.neg   <= b_neg;

      for (int j = 0; j < 3; j++) begin
        d_smag[j] <= shf[j][NORM_TOP-1:0];
        e_sq[j]   <= (2*NORM_TOP)'(d_smag[j]) * (2*NORM_TOP)'(d_smag[j]);
      end
      d_side <= c_side;
      e_smag <= d_smag;
      e_side <= d_side;

      sq   <= SQ_W'(e_sq[0]) + SQ_W'(e_sq[1]) + SQ_W'(e_sq[2]);
      smag <= e_smag;
      side <= e_side;
    end
  end

endmodule

### hdl/tun_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module tun_sqrt import tun_pkg::*; #(
  parameter int TAG_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   sq,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [TAG_W-1:0]  out_tag
);

  logic [SQ_W-1:0]  s_q [ROOT_W];
  logic [SQ_W-1:0]  r_q [ROOT_W];
  logic [TAG_W-1:0] t_q [ROOT_W];
  logic [ROOT_W-1:0] v_q;

  logic [SQ_W-1:0]  s_in [ROOT_W];
  logic [SQ_W-1:0]  r_in [ROOT_W];
  logic [TAG_W-1:0] t_in [ROOT_W];
  logic [SQ_W-1:0]  s_nx [ROOT_W];
  logic [SQ_W-1:0]  r_nx [ROOT_W];
  logic [SQ_W-1:0]  bitv [ROOT_W];
  logic [SQ_W-1:0]  trial [ROOT_W];

  always_comb begin
    s_in[0] = sq;
    r_in[0] = '0;
    t_in[0] = in_tag;
    for (int k = 1; k < ROOT_W; k++) begin
      s_in[k] = s_q[k-1];
      r_in[k] = r_q[k-1];
      t_in[k] = t_q[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      bitv[k]  = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
      trial[k] = r_in[k] + bitv[k];
      if (s_in[k] >= trial[k]) begin
        s_nx[k] = s_in[k] - trial[k];
        r_nx[k] = (r_in[k] >> 1) + bitv[k];
      end else begin
        s_nx[k] = s_in[k];
        r_nx[k] = r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[ROOT_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_q <= s_nx;
      r_q <= r_nx;
      t_q <= t_in;
    end
  end

  assign out_valid = v_q[ROOT_W-1];
  assign root      = r_q[ROOT_W-1][ROOT_W-1:0];
  assign out_tag   = t_q[ROOT_W-1];

endmodule

### hdl/tun_div.sv
// Pipelined restoring divider, three lanes over one common divisor.
module tun_div import tun_pkg::*; #(
  parameter int NUM_W = 45,
  parameter int QUO_W = 16,
  parameter int TAG_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num [3],
  input  logic [ROOT_W-1:0] den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo [3],
  output logic [TAG_W-1:0]  out_tag
);

  localparam int RW = ROOT_W + 1;

  logic [RW-1:0]     rem_q [QUO_W][3];
  logic [QUO_W-1:0]  nq_q  [QUO_W][3];
  logic [ROOT_W-1:0] den_q [QUO_W];
  logic [TAG_W-1:0]  tag_q [QUO_W];
  logic [QUO_W-1:0]  v_q;

  logic [RW-1:0]     rem_in [QUO_W][3];
  logic [QUO_W-1:0]  nq_in  [QUO_W][3];
  logic [ROOT_W-1:0] den_in [QUO_W];
  logic [TAG_W-1:0]  tag_in [QUO_W];
  logic [RW-1:0]     rem_nx [QUO_W][3];
  logic [QUO_W-1:0]  nq_nx  [QUO_W][3];
  logic [RW-1:0]     t      [QUO_W][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rem_in[0][j] = RW'(num[j] >> QUO_W);
      nq_in[0][j]  = num[j][QUO_W-1:0];
    end
    den_in[0] = den;
    tag_in[0] = in_tag;
    for (int k = 1; k < QUO_W; k++) begin
      rem_in[k] = rem_q[k-1];
      nq_in[k]  = nq_q[k-1];
      den_in[k] = den_q[k-1];
      tag_in[k] = tag_q[k-1];
    end
    // shift in the next numerator bit; quotient bits fill from the bottom
    for (int k = 0; k < QUO_W; k++) begin
      for (int j = 0; j < 3; j++) begin
        t[k][j] = {rem_in[k][j][RW-2:0], nq_in[k][j][QUO_W-1]};
        if (t[k][j] >= RW'(den_in[k])) begin
          rem_nx[k][j] = t[k][j] - RW'(den_in[k]);
          nq_nx[k][j]  = {nq_in[k][j][QUO_W-2:0], 1'b1};
        end else begin
          rem_nx[k][j] = t[k][j];
          nq_nx[k][j]  = {nq_in[k][j][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q <= rem_nx;
      nq_q  <= nq_nx;
      den_q <= den_in;
      tag_q <= tag_in;
    end
  end

  assign out_valid = v_q[QUO_W-1];
  assign quo       = nq_q[QUO_W-1];
  assign out_tag   = tag_q[QUO_W-1];

endmodule

### hdl/triangle_unit_normal.sv
// Top level: triangle vertices in, unit plane normal out.
//
//   channel  handshake               payload
//   in       in_valid / in_stall     x1 y1 z1 x2 y2 z2 x3 y3 z3
//   out      out_valid / out_stall   normal_x normal_y normal_z degenerate
//
// One request enters per cycle while in_stall is low; the path runs through the
// cross product, normalisation, the 31-stage square root and the quotient
// stages of the divider, then the output register.
// rst clears the valid bits of every stage; payload registers are not reset.
// A held result at the output freezes the whole pipeline and raises in_stall.
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] z1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  input  logic signed [COORD_BITS-1:0] z2,
  input  logic signed [COORD_BITS-1:0] x3,
  input  logic signed [COORD_BITS-1:0] y3,
  input  logic signed [COORD_BITS-1:0] z3,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_W-1:0]      normal_x,
  output logic signed [OUT_W-1:0]      normal_y,
  output logic signed [OUT_W-1:0]      normal_z,
  output logic                         degenerate
);

  localparam int MAG_W = 2 * COORD_BITS + 1;
  localparam int NUM_W = NORM_TOP + NORMAL_FRAC_BITS + 1;
  localparam int QUO_W = NORMAL_FRAC_BITS + 2;
  localparam int SIDE_W = $bits(side_t);
  localparam int TAG_W = SIDE_W + 3 * NORM_TOP;
  localparam int QX_W  = QUO_W + OUT_W;

  logic                         en;
  logic signed [COORD_BITS-1:0] crd [3][3];
  logic                         cr_valid;
  logic [MAG_W-1:0]             cr_mag [3];
  logic [2:0]                   cr_neg;
  logic                         nm_valid;
  logic [SQ_W-1:0]              nm_sq;
  logic [NORM_TOP-1:0]          nm_smag [3];
  side_t                        nm_side;
  logic                         sr_valid;
  logic [ROOT_W-1:0]            sr_root;
  logic [TAG_W-1:0]             sr_tag;
  logic [NUM_W-1:0]             dv_num [3];
  side_t                        sr_side;
  logic                         dv_valid;
  logic [QUO_W-1:0]             dv_quo [3];
  logic [SIDE_W-1:0]            dv_tag;
  side_t                        dv_side;
  logic [QUO_W-1:0]             qc [3];
  logic signed [QX_W-1:0]       qs [3];

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  always_comb begin
    crd[0][0] = x1; crd[0][1] = y1; crd[0][2] = z1;
    crd[1][0] = x2; crd[1][1] = y2; crd[1][2] = z2;
    crd[2][0] = x3; crd[2][1] = y3; crd[2][2] = z3;
  end

  tun_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk, .rst, .en,
    .in_valid  (in_valid),
    .crd       (crd),
    .out_valid (cr_valid),
    .mag       (cr_mag),
    .neg       (cr_neg)
  );

  tun_norm #(.MAG_W(MAG_W)) u_norm (
    .clk, .rst, .en,
    .in_valid  (cr_valid),
    .mag       (cr_mag),
    .neg       (cr_neg),
    .out_valid (nm_valid),
    .sq        (nm_sq),
    .smag      (nm_smag),
    .side      (nm_side)
  );

  tun_sqrt #(.TAG_W(TAG_W)) u_sqrt (
    .clk, .rst, .en,
    .in_valid  (nm_valid),
    .sq        (nm_sq),
    .in_tag    ({nm_side, nm_smag[0], nm_smag[1], nm_smag[2]}),
    .out_valid (sr_valid),
    .root      (sr_root),
    .out_tag   (sr_tag)
  );

  // round half away: add half the length before dividing
  always_comb begin
    sr_side = side_t'(sr_tag[TAG_W-1 -: SIDE_W]);
    for (int j = 0; j < 3; j++) begin
      dv_num[j] = (NUM_W'(sr_tag[(2-j)*NORM_TOP +: NORM_TOP]) << NORMAL_FRAC_BITS)
                + NUM_W'(sr_root >> 1);
    end
  end

  tun_div #(.NUM_W(NUM_W), .QUO_W(QUO_W), .TAG_W(SIDE_W)) u_div (
    .clk, .rst, .en,
    .in_valid  (sr_valid),
    .num       (dv_num),
    .den       (sr_root),
    .in_tag    (sr_side),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .out_tag   (dv_tag)
  );

  // limit to one, apply the sign, zero out a degenerate triangle
  always_comb begin
    dv_side = side_t'(dv_tag);
    for (int j = 0; j < 3; j++) begin
      qc[j] = (dv_quo[j] > (QUO_W'(1) << NORMAL_FRAC_BITS))
            ? (QUO_W'(1) << NORMAL_FRAC_BITS) : dv_quo[j];
      qs[j] = dv_side.neg[j] ? -$signed(QX_W'(qc[j])) : $signed(QX_W'(qc[j]));
      if (dv_side.degen) qs[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_x   <= qs[0][OUT_W-1:0];
      normal_y   <= qs[1][OUT_W-1:0];
      normal_z   <= qs[2][OUT_W-1:0];
      degenerate <= dv_side.degen;
    end
  end

endmodule

### bench/triangle_unit_normal_test.sv
// Testbench for the triangle unit normal pipeline: directed table then random triangles.
`timescale 1ns / 100ps

module triangle_unit_normal_test import tun_pkg::*;;

  localparam int CW        = COORD_BITS_DEF;
  localparam int FRAC      = NORMAL_FRAC_BITS_DEF;
  localparam int N_RANDOM  = 450;
  localparam int IDLE_MAX  = 5000;
  localparam int DRAIN_CYC = 70;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    degen;
  } normal_t;

  typedef struct packed {
    coord_t  x1, y1, z1, x2, y2, z2, x3, y3, z3;
    logic    typed_in;
    normal_t want;
  } tri_row_t;

  localparam normal_t NONE = '0;
  localparam normal_t DEGEN = '{nx: 16'sd0, ny: 16'sd0, nz: 16'sd0, degen: 1'b1};

  tri_row_t directed [12] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, DEGEN},
    '{0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}},
    '{0, 0, 0, 0, 256, 0, 256, 0, 0, 1'b1, '{16'sd0, 16'sd0, 16'sd16384, 1'b0}},
    '{0, 0, 0, 0, 256, 0, 0, 0, 256, 1'b1, '{-16'sd16384, 16'sd0, 16'sd0, 1'b0}},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1, DEGEN},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1, DEGEN},
    '{0, 0, 0, 256, 256, 256, 512, 512, 512, 1'b1, DEGEN},
    '{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767, 1'b0, NONE},
    '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 1'b0, NONE},
    '{-1, -1, -1, 0, 0, 0, 1, 0, -1, 1'b0, NONE},
    '{32767, -32768, 0, -32768, 32767, 32767, 0, 0, -32768, 1'b0, NONE},
    '{1, 0, 0, 0, 1, 0, 0, 0, 0, 1'b0, NONE}
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t x1 = '0, y1 = '0, z1 = '0, x2 = '0, y2 = '0, z2 = '0, x3 = '0, y3 = '0, z3 = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
  logic   degenerate;

  normal_t pending_normals [$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;
  int      stall_left = 0;

  triangle_unit_normal uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x1(x1), .y1(y1), .z1(z1), .x2(x2), .y2(y2), .z2(z2), .x3(x3), .y3(y3), .z3(z3),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] unit_component(bit neg, longint unsigned mag,
                                                              longint unsigned len);
    longint unsigned q;
    q = ((mag << FRAC) + (len >> 1)) / len;
    if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
    if (neg) q = 64'd0 - q;
    return q[OUT_W-1:0];
  endfunction

  function automatic normal_t face_normal(tri_row_t t);
    longint ca, cb, cc;
    longint unsigned ma, mb, mc, m, s, len;
    int bits;
    normal_t n;
    ca = -(longint'(t.y1) * (t.z2 - t.z3) + longint'(t.y2) * (t.z3 - t.z1)
           + longint'(t.y3) * (t.z1 - t.z2));
    cb = -(longint'(t.z1) * (t.x2 - t.x3) + longint'(t.z2) * (t.x3 - t.x1)
           + longint'(t.z3) * (t.x1 - t.x2));
    cc = -(longint'(t.x1) * (t.y2 - t.y3) + longint'(t.x2) * (t.y3 - t.y1)
           + longint'(t.x3) * (t.y1 - t.y2));
    ma = ca < 0 ? -ca : ca;
    mb = cb < 0 ? -cb : cb;
    mc = cc < 0 ? -cc : cc;
    m = ma;
    if (mb > m) m = mb;
    if (mc > m) m = mc;
    if (m == 0) return DEGEN;
    bits = 0;
    while ((m >> bits) != 0) bits++;
    // bring the largest magnitude's top bit to bit 29
    if (bits > NORM_TOP) begin
      ma >>= bits - NORM_TOP; mb >>= bits - NORM_TOP; mc >>= bits - NORM_TOP;
    end else begin
      ma <<= NORM_TOP - bits; mb <<= NORM_TOP - bits; mc <<= NORM_TOP - bits;
    end
    s = ma * ma + mb * mb + mc * mc;
    len = root_floor(s);
    n.nx = unit_component(ca < 0, ma, len);
    n.ny = unit_component(cb < 0, mb, len);
    n.nz = unit_component(cc < 0, mc, len);
    n.degen = 1'b0;
    return n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic coord_t edge_value();
    case ($urandom_range(4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic coord_t small_coord();
    return coord_t'(int'($urandom_range(1024)) - 512);
  endfunction

  function automatic tri_row_t random_triangle();
    tri_row_t t;
    int kind, d1, d2, d3;
    t = '0;
    kind = $urandom_range(99);
    if (kind < 40) begin
      {t.x1, t.y1, t.z1, t.x2, t.y2, t.z2} = {$urandom, $urandom, $urandom};
      {t.x3, t.y3, t.z3} = 48'({$urandom, $urandom});
    end else if (kind < 70) begin
      t.x1 = small_coord(); t.y1 = small_coord(); t.z1 = small_coord();
      t.x2 = small_coord(); t.y2 = small_coord(); t.z2 = small_coord();
      t.x3 = small_coord(); t.y3 = small_coord(); t.z3 = small_coord();
    end else if (kind < 85) begin
      // collinear or coincident vertices
      t.x1 = coord_t'(int'($urandom_range(20000)) - 10000);
      t.y1 = coord_t'(int'($urandom_range(20000)) - 10000);
      t.z1 = coord_t'(int'($urandom_range(20000)) - 10000);
      d1 = int'($urandom_range(10000)) - 5000; d2 = int'($urandom_range(10000)) - 5000;
      d3 = int'($urandom_range(10000)) - 5000;
      if ($urandom_range(3) == 0) begin
        d1 = 0; d2 = 0; d3 = 0;
      end
      t.x2 = coord_t'(int'(t.x1) + d1); t.y2 = coord_t'(int'(t.y1) + d2);
      t.z2 = coord_t'(int'(t.z1) + d3);
      t.x3 = coord_t'(int'(t.x1) + 2 * d1); t.y3 = coord_t'(int'(t.y1) + 2 * d2);
      t.z3 = coord_t'(int'(t.z1) + 2 * d3);
    end else begin
      t.x1 = edge_value(); t.y1 = edge_value(); t.z1 = edge_value();
      t.x2 = edge_value(); t.y2 = edge_value(); t.z2 = edge_value();
      t.x3 = edge_value(); t.y3 = edge_value(); t.z3 = edge_value();
    end
    return t;
  endfunction

  task automatic send_triangle(tri_row_t t);
    int gap;
    in_valid <= 1'b1;
    {x1, y1, z1, x2, y2, z2, x3, y3, z3} <=
      {t.x1, t.y1, t.z1, t.x2, t.y2, t.z2, t.x3, t.y3, t.z3};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // predict on every accepted request
  always @(posedge clk) begin
    tri_row_t seen;
    if (!rst && in_valid && !in_stall) begin
      seen = '0;
      {seen.x1, seen.y1, seen.z1, seen.x2, seen.y2, seen.z2, seen.x3, seen.y3, seen.z3} =
        {x1, y1, z1, x2, y2, z2, x3, y3, z3};
      pending_normals.push_back(face_normal(seen));
    end
  end

  always @(posedge clk) begin
    normal_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{normal_x, normal_y, normal_z, degenerate};
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = pending_normals.pop_front();
        if (got.nx !== want.nx) begin
          $display("%0t: normal_x expected %0d got %0d", $time, want.nx, got.nx);
          errors++;
        end
        if (got.ny !== want.ny) begin
          $display("%0t: normal_y expected %0d got %0d", $time, want.ny, got.ny);
          errors++;
        end
        if (got.nz !== want.nz) begin
          $display("%0t: normal_z expected %0d got %0d", $time, want.nz, got.nz);
          errors++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %0b got %0b", $time, want.degen, got.degen);
          errors++;
        end
      end
    end
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("triangle_unit_normal_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tri_row_t row;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      row = directed[i];
      if (!row.typed_in) row.want = face_normal(row);
      if (row.want != face_normal(row)) begin
        $display("%0t: table row %0d expected %p predicted %p", $time, i, row.want,
                 face_normal(row));
        errors++;
      end
      send_triangle(row);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      calm <= (i >= 150 && i < 210);
      if (i == 300) begin
        // hold until the pipe has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_normals.size() != 0) @(posedge clk);
      end
      send_triangle(random_triangle());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && pending_normals.size() == 0) begin
      $display("triangle_unit_normal_test passed");
    end else begin
      $display("triangle_unit_normal_test failed");
    end
    $finish;
  end

endmodule
